/* rtl/tmbg_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the trimmed-mean battery gauge.
package tmbg_pkg;

   // Configuration register indexes.
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 12;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BATCH_SELECT = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ZERO_FLOOR   = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEADBAND     = 2'd2;

   localparam int LEVEL_BITS = 12;
   localparam int CV_BITS    = 11;
   localparam int DIGIT_BITS = 4;

   localparam logic [LEVEL_BITS-1:0] ZERO_FLOOR_RESET = 12'd30;
   localparam logic [LEVEL_BITS-1:0] DEADBAND_RESET   = 12'd15;
   localparam logic [LEVEL_BITS-1:0] LEVEL_MAX        = 12'd4095;

   // Batch geometry of the alternate mode, and the trim of the full mode.
   localparam int ALT_BATCH   = 10;
   localparam int ALT_RANK_LO = 1;
   localparam int ALT_RANK_HI = 8;
   localparam int FULL_RANK_LO = 3;
   localparam int FULL_TRIM_HI = 4;
   localparam int ALT_MEAN_SHIFT = 3;

   // centivolts = floor(level * 48510 / (47 * 4096)).
   localparam int CV_NUM_BITS = 16;
   localparam logic [CV_NUM_BITS-1:0] CV_NUM = 16'd48510;
   localparam int SCALE_BITS = LEVEL_BITS + CV_NUM_BITS;
   localparam int QUOT_BITS  = SCALE_BITS - 12;
   // floor(q / 47) = (q * 89241) >> 22, exact for q below 182361.
   localparam int DIV47_BITS  = 17;
   localparam logic [DIV47_BITS-1:0] DIV47_RECIP = 17'd89241;
   localparam int DIV47_SHIFT = 22;

   // floor(cv / 100) = (cv * 1311) >> 17 and floor(cv / 10) = (cv * 1639) >> 14.
   localparam int DIV100_BITS  = 11;
   localparam logic [DIV100_BITS-1:0] DIV100_RECIP = 11'd1311;
   localparam int DIV100_SHIFT = 17;
   localparam int DIV10_BITS   = 11;
   localparam logic [DIV10_BITS-1:0] DIV10_RECIP = 11'd1639;
   localparam int DIV10_SHIFT  = 14;
   localparam int HUND_BITS    = 4;
   localparam int TENS_Q_BITS  = 7;

   typedef enum logic [2:0] {
      ST_COLLECT,
      ST_SUM,
      ST_MEAN,
      ST_LEVEL,
      ST_SCALE,
      ST_DIVIDE,
      ST_DIGIT,
      ST_HOLD
   } state_type;

   typedef struct packed {
      logic insert;
      logic sum_clear;
      logic sum_add;
      logic mean_load;
      logic level_load;
      logic scale_load;
      logic div_load;
      logic digit_load;
      logic out_load;
   } cmd_type;

endpackage

/* rtl/tmbg_ctrl.sv */
`timescale 1ns / 1ps
// Controller: batch counting, rank walk and the sequencing of the datapath.
module tmbg_ctrl #(
   parameter int MAX_BATCH = 16,
   parameter int CNT_BITS  = 5,
   parameter int IDX_BITS  = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic                  batch_select,
   output tmbg_pkg::cmd_type     cmd,
   output logic [IDX_BITS-1:0]   insert_pos,
   output logic [IDX_BITS-1:0]   rank
);
   import tmbg_pkg::*;

   state_type             state_ff, state_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic [IDX_BITS-1:0]   rank_ff, rank_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic [CNT_BITS-1:0]   batch_len;
   logic [CNT_BITS-1:0]   pos;
   logic                  last_sample;
   logic                  accept;
   logic                  out_free;
   logic [IDX_BITS-1:0]   rank_lo;
   logic [IDX_BITS-1:0]   rank_hi;

   assign batch_len = batch_select ? CNT_BITS'(ALT_BATCH) : CNT_BITS'(MAX_BATCH);
   assign rank_lo   = batch_select ? IDX_BITS'(ALT_RANK_LO) : IDX_BITS'(FULL_RANK_LO);
   assign rank_hi   = batch_select ? IDX_BITS'(ALT_RANK_HI)
                                   : IDX_BITS'(MAX_BATCH - FULL_TRIM_HI);

   // A mode change can leave the count at or past the new length; the
   // partial batch is then dropped and this request starts a new one.
   assign pos         = (count_ff >= batch_len) ? '0 : count_ff;
   assign last_sample = (pos + CNT_BITS'(1)) == batch_len;
   assign accept      = (state_ff == ST_COLLECT) && req_valid;
   assign out_free    = !rsp_valid_ff || !rsp_stall;

   assign insert_pos = pos[IDX_BITS-1:0];
   assign rank       = rank_ff;
   assign rsp_valid  = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_COLLECT: begin
            if (accept && last_sample) state_in = ST_SUM;
         end
         ST_SUM: begin
            if (rank_ff == rank_hi) state_in = ST_MEAN;
         end
         ST_MEAN:   state_in = ST_LEVEL;
         ST_LEVEL:  state_in = ST_SCALE;
         ST_SCALE:  state_in = ST_DIVIDE;
         ST_DIVIDE: state_in = ST_DIGIT;
         ST_DIGIT:  state_in = ST_HOLD;
         ST_HOLD: begin
            if (out_free) state_in = ST_COLLECT;
         end
         default:   state_in = ST_COLLECT;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_COLLECT: begin
            req_stall     = 1'b0;
            cmd.insert    = req_valid;
            cmd.sum_clear = accept && last_sample;
         end
         ST_SUM:    cmd.sum_add    = 1'b1;
         ST_MEAN:   cmd.mean_load  = 1'b1;
         ST_LEVEL:  cmd.level_load = 1'b1;
         ST_SCALE:  cmd.scale_load = 1'b1;
         ST_DIVIDE: cmd.div_load   = 1'b1;
         ST_DIGIT:  cmd.digit_load = 1'b1;
         ST_HOLD:   cmd.out_load   = out_free;
         default:   cmd            = '0;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (accept) begin
         count_in = last_sample ? '0 : pos + CNT_BITS'(1);
      end
      rank_in = rank_ff;
      if (accept && last_sample) begin
         rank_in = rank_lo;
      end else if (state_ff == ST_SUM) begin
         rank_in = rank_ff + IDX_BITS'(1);
      end
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_COLLECT;
         count_ff     <= '0;
         rank_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rank_ff      <= rank_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* rtl/tmbg_dp.sv */
`timescale 1ns / 1ps
// Datapath: sorted sample file, trimmed sum, mean, zero floor, deadband, voltage scaling and decimal digits.
module tmbg_dp #(
   parameter int MAX_BATCH   = 16,
   parameter int SAMPLE_BITS = 12,
   parameter int IDX_BITS    = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  tmbg_pkg::cmd_type                   cmd,
   input  logic [IDX_BITS-1:0]                 insert_pos,
   input  logic [IDX_BITS-1:0]                 rank,
   input  logic                                batch_select,
   input  logic [tmbg_pkg::LEVEL_BITS-1:0]     zero_floor,
   input  logic [tmbg_pkg::LEVEL_BITS-1:0]     deadband,
   input  logic [SAMPLE_BITS-1:0]              sample,
   output logic [tmbg_pkg::LEVEL_BITS-1:0]     level,
   output logic [tmbg_pkg::CV_BITS-1:0]        centivolts,
   output logic [tmbg_pkg::DIGIT_BITS-1:0]     digit_hundreds,
   output logic [tmbg_pkg::DIGIT_BITS-1:0]     digit_tens,
   output logic [tmbg_pkg::DIGIT_BITS-1:0]     digit_ones
);
   import tmbg_pkg::*;

   localparam int SUM_BITS   = SAMPLE_BITS + 4;
   localparam int FULL_DIV   = MAX_BATCH - FULL_TRIM_HI - FULL_RANK_LO + 1;
   localparam int RECIP_SHIFT = SUM_BITS + 4;
   localparam int RECIP_BITS = RECIP_SHIFT;
   localparam logic [RECIP_BITS-1:0] FULL_RECIP =
      RECIP_BITS'(((64'd1 << RECIP_SHIFT) + 64'(FULL_DIV) - 64'd1) / 64'(FULL_DIV));
   localparam int MEAN_PROD_BITS = SUM_BITS + RECIP_BITS;
   localparam int WIDE_BITS = (SAMPLE_BITS > LEVEL_BITS) ? SAMPLE_BITS : LEVEL_BITS;

   logic [SAMPLE_BITS-1:0]  sorted_ff [MAX_BATCH];
   logic [SAMPLE_BITS-1:0]  sorted_in [MAX_BATCH];
   logic [MAX_BATCH-1:0]    gt;
   logic [MAX_BATCH-1:0]    gt_prev;

   logic [SUM_BITS-1:0]     sum_ff, sum_in;
   logic [SAMPLE_BITS-1:0]  mean_ff, mean_in;
   logic [MEAN_PROD_BITS-1:0] mean_prod;
   logic [LEVEL_BITS-1:0]   prev_level_ff, prev_level_in;
   logic [QUOT_BITS-1:0]    quot_ff;
   logic [SCALE_BITS-1:0]   scale_prod;
   logic [CV_BITS-1:0]      cv_ff;
   logic [QUOT_BITS+DIV47_BITS-1:0] cv_prod;
   logic [HUND_BITS-1:0]    hund_q_ff;
   logic [TENS_Q_BITS-1:0]  tens_q_ff;
   logic [CV_BITS+DIV100_BITS-1:0] hund_prod;
   logic [CV_BITS+DIV10_BITS-1:0]  tens_prod;

   logic [WIDE_BITS-1:0]    mean_wide;
   logic [LEVEL_BITS-1:0]   lvl_sat;
   logic [LEVEL_BITS-1:0]   lvl_floor;
   logic [LEVEL_BITS-1:0]   lvl_diff;

   logic [LEVEL_BITS-1:0]   level_ff;
   logic [CV_BITS-1:0]      centivolts_ff;
   logic [DIGIT_BITS-1:0]   hundreds_ff, tens_ff, ones_ff;
   logic [HUND_BITS-1:0]    hund_wrap;
   logic [TENS_Q_BITS-1:0]  tens_full;
   logic [CV_BITS-1:0]      ones_full;

   // Insertion into the sorted file: every entry at or below the insert
   // position either keeps its value, takes its lower neighbor, or takes
   // the new sample, so the file stays in ascending order.
   always_comb begin
      for (int i = 0; i < MAX_BATCH; i++) begin
         gt[i] = sorted_ff[i] > sample;
      end
      gt_prev = {gt[MAX_BATCH-2:0], 1'b0};
      for (int i = 0; i < MAX_BATCH; i++) begin
         sorted_in[i] = sorted_ff[i];
         if (IDX_BITS'(i) <= insert_pos) begin
            if (IDX_BITS'(i) != insert_pos && !gt[i]) begin
               sorted_in[i] = sorted_ff[i];
            end else if (gt_prev[i]) begin
               sorted_in[i] = sorted_ff[(i > 0) ? i - 1 : 0];
            end else begin
               sorted_in[i] = sample;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.insert) begin
         for (int i = 0; i < MAX_BATCH; i++) begin
            sorted_ff[i] <= sorted_in[i];
         end
      end
   end

   // Trimmed sum, one rank per cycle.
   assign sum_in = cmd.sum_clear ? '0 : sum_ff + SUM_BITS'(sorted_ff[rank]);

   always_ff @(posedge clock) begin
      if (cmd.sum_clear || cmd.sum_add) begin
         sum_ff <= sum_in;
      end
   end

   // Mean: shift for eight ranks, reciprocal multiply otherwise.
   assign mean_prod = MEAN_PROD_BITS'(sum_ff) * MEAN_PROD_BITS'(FULL_RECIP);
   assign mean_in = batch_select ? SAMPLE_BITS'(sum_ff >> ALT_MEAN_SHIFT)
                                 : SAMPLE_BITS'(mean_prod >> RECIP_SHIFT);

   always_ff @(posedge clock) begin
      if (cmd.mean_load) begin
         mean_ff <= mean_in;
      end
   end

   // Saturate, apply the zero floor, then the deadband against the last level.
   always_comb begin
      mean_wide = WIDE_BITS'(mean_ff);
      lvl_sat   = (mean_wide > WIDE_BITS'(LEVEL_MAX)) ? LEVEL_MAX
                                                      : LEVEL_BITS'(mean_wide);
      lvl_floor = (lvl_sat < zero_floor) ? '0 : lvl_sat;
      lvl_diff  = (lvl_floor > prev_level_ff) ? lvl_floor - prev_level_ff
                                              : prev_level_ff - lvl_floor;
      prev_level_in = (lvl_diff < deadband) ? prev_level_ff : lvl_floor;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_level_ff <= '0;
      end else if (cmd.level_load) begin
         prev_level_ff <= prev_level_in;
      end
   end

   // Voltage scaling: multiply by 48510, drop 12 bits, then divide by 47.
   assign scale_prod = SCALE_BITS'(prev_level_ff) * SCALE_BITS'(CV_NUM);
   assign cv_prod    = (QUOT_BITS + DIV47_BITS)'(quot_ff)
                     * (QUOT_BITS + DIV47_BITS)'(DIV47_RECIP);
   assign hund_prod  = (CV_BITS + DIV100_BITS)'(cv_ff)
                     * (CV_BITS + DIV100_BITS)'(DIV100_RECIP);
   assign tens_prod  = (CV_BITS + DIV10_BITS)'(cv_ff)
                     * (CV_BITS + DIV10_BITS)'(DIV10_RECIP);

   always_ff @(posedge clock) begin
      if (cmd.scale_load) begin
         quot_ff <= scale_prod[SCALE_BITS-1 -: QUOT_BITS];
      end
      if (cmd.div_load) begin
         cv_ff <= CV_BITS'(cv_prod >> DIV47_SHIFT);
      end
      if (cmd.digit_load) begin
         hund_q_ff <= HUND_BITS'(hund_prod >> DIV100_SHIFT);
         tens_q_ff <= TENS_Q_BITS'(tens_prod >> DIV10_SHIFT);
      end
   end

   // Decimal digits: cv/10 divided by ten is cv/100, so only times-ten
   // products remain here.
   always_comb begin
      hund_wrap = (hund_q_ff >= HUND_BITS'(10)) ? hund_q_ff - HUND_BITS'(10) : hund_q_ff;
      tens_full = tens_q_ff - ((TENS_Q_BITS'(hund_q_ff) << 3) + (TENS_Q_BITS'(hund_q_ff) << 1));
      ones_full = cv_ff - ((CV_BITS'(tens_q_ff) << 3) + (CV_BITS'(tens_q_ff) << 1));
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         level_ff      <= prev_level_ff;
         centivolts_ff <= cv_ff;
         hundreds_ff   <= DIGIT_BITS'(hund_wrap);
         tens_ff       <= tens_full[DIGIT_BITS-1:0];
         ones_ff       <= ones_full[DIGIT_BITS-1:0];
      end
   end

   assign level          = level_ff;
   assign centivolts     = centivolts_ff;
   assign digit_hundreds = hundreds_ff;
   assign digit_tens     = tens_ff;
   assign digit_ones     = ones_ff;

endmodule

/* rtl/trimmed_mean_battery_gauge_top.sv */
`timescale 1ns / 1ps
// Top level of the trimmed-mean battery gauge: configuration registers and wiring.
//
// Each request carries one ADC sample. Samples are inserted into an ascending
// register file as they arrive, one per cycle with no stall. The request that
// completes a batch (MAX_BATCH samples, or 10 when batch_select is set) holds
// the request channel for a walk over the middle ranks, one rank per cycle,
// followed by the mean, floor and deadband, scaling, division and decimal digit
// steps, and by a hold step that also waits while rsp_stall keeps the response
// register full. One response is produced per completed batch, and the response
// register lets a new batch be collected while that response waits. The sample
// file needs no clearing after reset; only entries written in the current batch
// are read.
module trimmed_mean_battery_gauge_top #(
   parameter int MAX_BATCH   = 16,
   parameter int SAMPLE_BITS = 12
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [SAMPLE_BITS-1:0]                 req_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [tmbg_pkg::LEVEL_BITS-1:0]        rsp_level,
   output logic [tmbg_pkg::CV_BITS-1:0]           rsp_centivolts,
   output logic [tmbg_pkg::DIGIT_BITS-1:0]        rsp_digit_hundreds,
   output logic [tmbg_pkg::DIGIT_BITS-1:0]        rsp_digit_tens,
   output logic [tmbg_pkg::DIGIT_BITS-1:0]        rsp_digit_ones,
   input  logic                                   csr_write_enable,
   input  logic [tmbg_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [tmbg_pkg::CSR_DATA_BITS-1:0]     csr_data
);
   import tmbg_pkg::*;

   localparam int CNT_BITS = $clog2(MAX_BATCH + 1);
   localparam int IDX_BITS = $clog2(MAX_BATCH);

   logic                   batch_select_ff, batch_select_in;
   logic [LEVEL_BITS-1:0]  zero_floor_ff, zero_floor_in;
   logic [LEVEL_BITS-1:0]  deadband_ff, deadband_in;

   cmd_type                cmd;
   logic [IDX_BITS-1:0]    insert_pos;
   logic [IDX_BITS-1:0]    rank;

   always_comb begin
      batch_select_in = batch_select_ff;
      zero_floor_in   = zero_floor_ff;
      deadband_in     = deadband_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_BATCH_SELECT: batch_select_in = csr_data[0];
            CSR_ZERO_FLOOR:   zero_floor_in   = csr_data[LEVEL_BITS-1:0];
            CSR_DEADBAND:     deadband_in     = csr_data[LEVEL_BITS-1:0];
            default:          batch_select_in = batch_select_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         batch_select_ff <= 1'b0;
         zero_floor_ff   <= ZERO_FLOOR_RESET;
         deadband_ff     <= DEADBAND_RESET;
      end else begin
         batch_select_ff <= batch_select_in;
         zero_floor_ff   <= zero_floor_in;
         deadband_ff     <= deadband_in;
      end
   end

   tmbg_ctrl #(
      .MAX_BATCH (MAX_BATCH),
      .CNT_BITS  (CNT_BITS),
      .IDX_BITS  (IDX_BITS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .batch_select (batch_select_ff),
      .cmd          (cmd),
      .insert_pos   (insert_pos),
      .rank         (rank)
   );

   tmbg_dp #(
      .MAX_BATCH   (MAX_BATCH),
      .SAMPLE_BITS (SAMPLE_BITS),
      .IDX_BITS    (IDX_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .insert_pos     (insert_pos),
      .rank           (rank),
      .batch_select   (batch_select_ff),
      .zero_floor     (zero_floor_ff),
      .deadband       (deadband_ff),
      .sample         (req_sample),
      .level          (rsp_level),
      .centivolts     (rsp_centivolts),
      .digit_hundreds (rsp_digit_hundreds),
      .digit_tens     (rsp_digit_tens),
      .digit_ones     (rsp_digit_ones)
   );

endmodule
